// ----- design/car1kl_pkg.sv -----
// Shared types and constants for the CAR(1) Kalman likelihood block.
// Used by car1_kalman_likelihood; depends on nothing.
package car1kl_pkg;

   typedef struct packed {
      logic [31:0]        obs_time;
      logic signed [31:0] magnitude;
      logic [31:0]        error_variance;
      logic               last_item;
   } car1kl_req_type;

   typedef struct packed {
      logic signed [47:0] neg2_log_likelihood;
      logic               failed;
      logic               curve_done;
   } car1kl_rsp_type;

   // register indexes
   localparam logic [1:0] CSR_SIGMA = 2'd0;
   localparam logic [1:0] CSR_TAU   = 2'd1;
   localparam logic [1:0] CSR_MEAN  = 2'd2;

   localparam logic [31:0] SIGMA_RESET = 32'h0100_0000;
   localparam logic [31:0] TAU_RESET   = 32'h0064_0000;
   localparam logic [31:0] MEAN_RESET  = 32'h0000_0000;
   localparam logic [39:0] OMEGA_RESET = 40'h00_0100_0000;

   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
   localparam logic [24:0] ONE_Q24  = 25'h100_0000;
   localparam logic [39:0] OMEGA_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [47:0] SUM_MAX  = 48'h7FFF_FFFF_FFFF;
   localparam logic [31:0] LN2_Q32  = 32'd2977044472;

   // floor(2^32 / k), k = 1..12; exact quotient after at most one correction
   function automatic logic [32:0] recip_q32(input logic [3:0] k);
      logic [32:0] r;
      case (k)
         4'd1:    r = 33'h1_0000_0000;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd1431655765;
         4'd4:    r = 33'd1073741824;
         4'd5:    r = 33'd858993459;
         4'd6:    r = 33'd715827882;
         4'd7:    r = 33'd613566756;
         4'd8:    r = 33'd536870912;
         4'd9:    r = 33'd477218588;
         4'd10:   r = 33'd429496729;
         4'd11:   r = 33'd390451572;
         4'd12:   r = 33'd357913941;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

   // exp(-f) Horner series, same steps as the hardware loop (elaboration only)
   function automatic logic [32:0] expneg_frac_c(input logic [32:0] f);
      logic [127:0] p;
      logic [127:0] tmp;
      logic [127:0] q;
      p = 128'(ONE_Q32);
      for (int k = 12; k >= 1; k--) begin
         tmp = (128'(f) * p) >> 32;
         q   = (tmp * 128'(recip_q32(4'(k)))) >> 32;
         if (tmp - q * 128'(k) >= 128'(k)) begin
            q = q + 128'd1;
         end
         p = 128'(ONE_Q32) - q;
      end
      return p[32:0];
   endfunction

   function automatic logic [31:0] e1_q32_c();
      logic [65:0] h;
      logic [65:0] sq;
      h  = 66'(expneg_frac_c(33'h0_8000_0000));
      sq = h * h + 66'h8000_0000;
      return sq[63:32];
   endfunction

   localparam logic [31:0] E1_Q32 = e1_q32_c();

   // ln(2*pi) - ln(2^24), Q16
   localparam logic [63:0] LN24_PROD = 64'd402653184 * 64'd2977044472;
   localparam logic [63:0] LN24_Q16  = (LN24_PROD + 64'h80_0000_0000) >> 40;
   localparam logic signed [49:0] LN_OFFSET = 50'sd120447 - $signed(LN24_Q16[49:0]);

endpackage

// ----- design/car1_kalman_likelihood.sv -----
// CAR(1) Kalman likelihood: sequencer around one shared 34x34 multiplier and a
// bit-serial 72/41 divider. Depends on car1kl_pkg.
//
// Work per item: up to three divisions with a 72-bit quotient, the 12-term exp
// series and the 24-step log2 loop; the first item of a curve skips the series
// and all but the last division. One item in flight; req_ready is high only when idle.
// A finished result waits in the rsp register while the next item is taken.
// Reset (synchronous): registers to their reset values, next item opens a curve.
module car1_kalman_likelihood (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  car1kl_pkg::car1kl_req_type  req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output car1kl_pkg::car1kl_rsp_type  rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_data
);
   import car1kl_pkg::*;

   // sequencer states
   localparam logic [5:0] S_IDLE = 6'd0,  S_SIG  = 6'd1,  S_SIG2 = 6'd2,  S_DT   = 6'd3;
   localparam logic [5:0] S_DIV  = 6'd4,  S_EXP0 = 6'd5,  S_H1   = 6'd6,  S_H2   = 6'd7;
   localparam logic [5:0] S_H3   = 6'd8,  S_H4   = 6'd9,  S_E1   = 6'd10, S_E2   = 6'd11;
   localparam logic [5:0] S_A2   = 6'd12, S_A2B  = 6'd13, S_K    = 6'd14, S_IN0  = 6'd15;
   localparam logic [5:0] S_IN1  = 6'd16, S_IN2  = 6'd17, S_IN3  = 6'd18, S_IN4  = 6'd19;
   localparam logic [5:0] S_IN5  = 6'd20, S_IN6  = 6'd21, S_IN7  = 6'd22, S_IN8  = 6'd23;
   localparam logic [5:0] S_M1   = 6'd24, S_M2   = 6'd25, S_M3   = 6'd26, S_M4   = 6'd27;
   localparam logic [5:0] S_FCHK = 6'd28, S_NRM  = 6'd29, S_L1   = 6'd30, S_L2   = 6'd31;
   localparam logic [5:0] S_LN1  = 6'd32, S_LN2  = 6'd33, S_R0   = 6'd34, S_R1   = 6'd35;
   localparam logic [5:0] S_R2   = 6'd36, S_R3   = 6'd37, S_R4   = 6'd38, S_FIN  = 6'd39;

   // phases of the Omega update (three scaled products)
   localparam logic [1:0] PH_NOISE = 2'd0, PH_GAIN = 2'd1, PH_DECAY = 2'd2;

   localparam logic [6:0] DIV_LAST = 7'd71;

   // control
   logic [5:0]  state_ff, state_in, ret_ff, ret_in;
   // configuration
   logic [31:0] sigma_ff, sigma_in, tau_ff, tau_in;
   logic signed [31:0] mean_ff, mean_in;
   // filter state carried between items
   logic [39:0] omega_ff, omega_in;
   logic signed [31:0] pdev_ff, pdev_in, pmag_ff, pmag_in;
   logic [31:0] ptime_ff, ptime_in, pvar_ff, pvar_in;
   logic signed [47:0] sum_ff, sum_in;
   logic        fail_ff, fail_in, start_ff, start_in;
   // current item
   logic [31:0] t_ff, t_in, v_ff, v_in;
   logic signed [31:0] x_ff, x_in;
   logic        last_ff, last_in;
   // working registers
   logic [39:0] sl2_ff, sl2_in;
   logic [32:0] a_ff, a_in, a2_ff, a2_in;
   logic [24:0] k_ff, k_in;
   logic [31:0] f_ff, f_in, tmp_ff, tmp_in, quo_ff, quo_in, m_ff, m_in;
   logic [3:0]  hk_ff, hk_in;
   logic [4:0]  ncnt_ff, ncnt_in, it_ff, it_in;
   logic signed [36:0] d_ff, d_in;
   logic [33:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [1:0]  ph_ff, ph_in;
   logic [59:0] t40_ff, t40_in;
   logic [41:0] acc_ff, acc_in;
   logic [40:0] res_ff, res_in, nrm_ff, nrm_in, var_ff, var_in;
   logic [5:0]  e_ff, e_in;
   logic [23:0] frac_ff, frac_in;
   logic signed [49:0] lsum_ff, lsum_in;
   logic [67:0] prod_ff, prod_in;
   // divider
   logic [40:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [71:0] div_quo_ff, div_quo_in;
   logic [6:0]  div_cnt_ff, div_cnt_in;
   // result
   car1kl_rsp_type rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [33:0] mul_x, mul_y;
   logic [40:0] mx;
   logic [32:0] mq;
   logic [41:0] div_rsh;
   logic        div_ge;
   logic [41:0] div_diff;
   logic [31:0] dt;
   logic [40:0] denom;
   logic [36:0] dabs;
   logic [36:0] rnd_p24;
   logic [32:0] rnd_p32;
   logic signed [36:0] pdev_ext;
   logic [59:0] t40_rnd;
   logic [41:0] m40_res;
   logic [42:0] om_sum;
   logic [32:0] mm;
   logic [67:0] rnd_a;
   logic [31:0] h_rem;
   logic        h_inc;
   logic [61:0] ln_rnd;
   logic        ovf, fail_now;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Omega update operands per phase
   always_comb begin
      case (ph_ff)
         PH_NOISE: begin
            mx = {1'b0, sl2_ff};
            mq = ONE_Q32 - a2_ff;
         end
         PH_GAIN: begin
            mx = {1'b0, omega_ff};
            mq = {8'b0, ONE_Q24 - k_ff};
         end
         default: begin
            mx = res_ff;
            mq = a2_ff;
         end
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (state_ff)
         S_SIG: begin
            mul_x = {2'b0, sigma_ff};
            mul_y = {2'b0, sigma_ff};
         end
         S_H1: begin
            mul_x = {2'b0, f_ff};
            mul_y = {1'b0, a_ff};
         end
         S_H2: begin
            mul_x = {2'b0, prod_ff[63:32]};
            mul_y = {1'b0, recip_q32(hk_ff)};
         end
         S_H3: begin
            mul_x = {2'b0, prod_ff[63:32]};
            mul_y = {30'b0, hk_ff};
         end
         S_E1: begin
            mul_x = {1'b0, a_ff};
            mul_y = {2'b0, E1_Q32};
         end
         S_A2: begin
            mul_x = {1'b0, a_ff};
            mul_y = {1'b0, a_ff};
         end
         S_IN3: begin
            mul_x = mag_ff;
            mul_y = {9'b0, k_ff};
         end
         S_IN7: begin
            mul_x = mag_ff;
            mul_y = {1'b0, a_ff};
         end
         S_M1: begin
            mul_x = {9'b0, mx[40:16]};
            mul_y = {1'b0, mq};
         end
         S_M2: begin
            mul_x = {18'b0, mx[15:0]};
            mul_y = {1'b0, mq};
         end
         S_L1: begin
            mul_x = {2'b0, m_ff};
            mul_y = {2'b0, m_ff};
         end
         S_LN1: begin
            mul_x = {4'b0, e_ff, frac_ff};
            mul_y = {2'b0, LN2_Q32};
         end
         S_R2: begin
            mul_x = mag_ff;
            mul_y = mag_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;

   // divider step, restoring, one quotient bit a cycle
   assign div_rsh  = {div_rem_ff, div_quo_ff[71]};
   assign div_ge   = (div_rsh >= {1'b0, div_den_ff});
   assign div_diff = div_rsh - {1'b0, div_den_ff};

   // datapath helpers
   assign dt       = (t_ff < ptime_ff) ? 32'd0 : t_ff - ptime_ff;
   assign denom    = {1'b0, omega_ff} + {9'b0, pvar_ff};
   assign dabs     = d_ff[36] ? 37'(-d_ff) : 37'(d_ff);
   assign rnd_a    = prod_ff + 68'h8000_0000;
   assign rnd_p32  = rnd_a[64:32];
   assign pdev_ext = 37'(pdev_ff);
   assign t40_rnd  = (ph_ff == PH_GAIN) ? t40_ff + 60'h80 : t40_ff + 60'h8000;
   assign m40_res  = (ph_ff == PH_GAIN) ? t40_rnd[49:8] : t40_rnd[57:16];
   assign om_sum   = {1'b0, acc_ff} + {2'b0, m40_res[40:0]};
   assign mm       = prod_ff[63:31];
   assign h_rem    = tmp_ff - prod_ff[31:0];
   assign h_inc    = (h_rem >= {28'b0, hk_ff});
   assign ln_rnd   = prod_ff[61:0] + 62'h80_0000_0000;
   assign ovf      = (lsum_ff[49:47] != 3'b000) && (lsum_ff[49:47] != 3'b111);
   assign fail_now = fail_ff | ovf;

   always_comb begin
      logic [67:0] p24;
      p24 = prod_ff + 68'h80_0000;
      rnd_p24 = p24[60:24];
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      sigma_in    = sigma_ff;
      tau_in      = tau_ff;
      mean_in     = mean_ff;
      omega_in    = omega_ff;
      pdev_in     = pdev_ff;
      pmag_in     = pmag_ff;
      ptime_in    = ptime_ff;
      pvar_in     = pvar_ff;
      sum_in      = sum_ff;
      fail_in     = fail_ff;
      start_in    = start_ff;
      t_in        = t_ff;
      v_in        = v_ff;
      x_in        = x_ff;
      last_in     = last_ff;
      sl2_in      = sl2_ff;
      a_in        = a_ff;
      a2_in       = a2_ff;
      k_in        = k_ff;
      f_in        = f_ff;
      tmp_in      = tmp_ff;
      quo_in      = quo_ff;
      m_in        = m_ff;
      hk_in       = hk_ff;
      ncnt_in     = ncnt_ff;
      it_in       = it_ff;
      d_in        = d_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      ph_in       = ph_ff;
      t40_in      = t40_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      nrm_in      = nrm_ff;
      var_in      = var_ff;
      e_in        = e_ff;
      frac_in     = frac_ff;
      lsum_in     = lsum_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      div_quo_in  = div_quo_ff;
      div_cnt_in  = div_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_SIGMA: sigma_in = csr_data;
            CSR_TAU:   tau_in   = csr_data;
            CSR_MEAN:  mean_in  = $signed(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               t_in     = req_data.obs_time;
               x_in     = req_data.magnitude;
               v_in     = req_data.error_variance;
               last_in  = req_data.last_item;
               state_in = S_SIG;
            end
         end
         S_SIG: state_in = S_SIG2;
         S_SIG2: begin
            // sigma^2 rounded to Q16.24; cannot pass 40 bits
            sl2_in = prod_ff[63:24] + 40'(prod_ff[23]);
            if (start_ff) begin
               omega_in = prod_ff[63:24] + 40'(prod_ff[23]);
               pdev_in  = '0;
               sum_in   = '0;
               fail_in  = 1'b0;
               state_in = S_FCHK;
            end else begin
               state_in = S_DT;
            end
         end
         S_DT: begin
            if (t_ff < ptime_ff) begin
               fail_in = 1'b1;
            end
            if (tau_ff != '0) begin
               div_quo_in = {8'b0, dt, 32'b0};
               div_den_in = {9'b0, tau_ff};
               div_rem_in = '0;
               div_cnt_in = '0;
               ret_in     = S_EXP0;
               state_in   = S_DIV;
            end else begin
               a_in     = '0;
               state_in = S_A2;
            end
         end
         S_DIV: begin
            div_quo_in = {div_quo_ff[70:0], div_ge};
            div_rem_in = div_ge ? div_diff[40:0] : div_rsh[40:0];
            div_cnt_in = div_cnt_ff + 7'd1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ret_ff;
            end
         end
         S_EXP0: begin
            if ((|div_quo_ff[71:37]) || (div_quo_ff[36:32] >= 5'd24)) begin
               a_in     = '0;
               state_in = S_A2;
            end else begin
               f_in     = div_quo_ff[31:0];
               a_in     = ONE_Q32;
               hk_in    = 4'd12;
               ncnt_in  = div_quo_ff[36:32];
               state_in = S_H1;
            end
         end
         S_H1: state_in = S_H2;
         S_H2: begin
            tmp_in   = prod_ff[63:32];
            state_in = S_H3;
         end
         S_H3: begin
            quo_in   = prod_ff[63:32];
            state_in = S_H4;
         end
         S_H4: begin
            a_in  = ONE_Q32 - {1'b0, quo_ff} - 33'(h_inc);
            hk_in = hk_ff - 4'd1;
            state_in = (hk_ff == 4'd1) ? S_E1 : S_H1;
         end
         S_E1: state_in = (ncnt_ff == '0) ? S_A2 : S_E2;
         S_E2: begin
            a_in     = rnd_p32;
            ncnt_in  = ncnt_ff - 5'd1;
            state_in = S_E1;
         end
         S_A2: state_in = S_A2B;
         S_A2B: begin
            a2_in = (a_ff == ONE_Q32) ? ONE_Q32 : rnd_p32;
            if (denom != '0) begin
               div_quo_in = {8'b0, omega_ff, 24'b0};
               div_den_in = denom;
               div_rem_in = '0;
               div_cnt_in = '0;
               ret_in     = S_K;
               state_in   = S_DIV;
            end else begin
               k_in     = '0;
               state_in = S_IN0;
            end
         end
         S_K: begin
            k_in     = div_quo_ff[24:0];
            state_in = S_IN0;
         end
         S_IN0: begin
            d_in     = 37'(pmag_ff) - 37'(mean_ff);
            state_in = S_IN1;
         end
         S_IN1: begin
            d_in     = d_ff - pdev_ext;
            state_in = S_IN2;
         end
         S_IN2: begin
            neg_in   = d_ff[36];
            mag_in   = dabs[33:0];
            state_in = S_IN3;
         end
         S_IN3: state_in = S_IN4;
         S_IN4: begin
            d_in     = neg_ff ? pdev_ext - $signed(rnd_p24) : pdev_ext + $signed(rnd_p24);
            state_in = S_IN5;
         end
         S_IN5: begin
            // clamp the updated deviation to 32 bits
            if (d_ff[36:31] != 6'b000000 && d_ff[36:31] != 6'b111111) begin
               fail_in = 1'b1;
               d_in    = d_ff[36] ? -37'sd2147483648 : 37'sd2147483647;
            end
            state_in = S_IN6;
         end
         S_IN6: begin
            neg_in   = d_ff[36];
            mag_in   = dabs[33:0];
            state_in = S_IN7;
         end
         S_IN7: state_in = S_IN8;
         S_IN8: begin
            pdev_in  = neg_ff ? $signed(32'(-rnd_p32)) : $signed(rnd_p32[31:0]);
            ph_in    = PH_NOISE;
            state_in = S_M1;
         end
         S_M1: state_in = S_M2;
         S_M2: begin
            t40_in   = prod_ff[59:0];
            state_in = S_M3;
         end
         S_M3: begin
            t40_in   = t40_ff + {16'b0, prod_ff[59:16]};
            state_in = S_M4;
         end
         S_M4: begin
            case (ph_ff)
               PH_NOISE: begin
                  acc_in   = m40_res;
                  ph_in    = PH_GAIN;
                  state_in = S_M1;
               end
               PH_GAIN: begin
                  res_in   = m40_res[40:0];
                  ph_in    = PH_DECAY;
                  state_in = S_M1;
               end
               default: begin
                  omega_in = (om_sum > {3'b0, OMEGA_MAX}) ? OMEGA_MAX : om_sum[39:0];
                  state_in = S_FCHK;
               end
            endcase
         end
         S_FCHK: begin
            if (sigma_ff == '0 || tau_ff == '0 || v_ff == '0) begin
               fail_in = 1'b1;
            end
            var_in  = {1'b0, omega_ff} + {9'b0, v_ff};
            nrm_in  = {1'b0, omega_ff} + {9'b0, v_ff};
            e_in    = 6'd40;
            lsum_in = 50'(sum_ff);
            d_in    = 37'(x_ff) - 37'(mean_ff);
            state_in = (({1'b0, omega_ff} + {9'b0, v_ff}) == '0) ? S_FIN : S_NRM;
         end
         S_NRM: begin
            if (nrm_ff[40]) begin
               m_in     = nrm_ff[40:9];
               frac_in  = '0;
               it_in    = 5'd24;
               state_in = S_L1;
            end else begin
               nrm_in = {nrm_ff[39:0], 1'b0};
               e_in   = e_ff - 6'd1;
            end
         end
         S_L1: state_in = S_L2;
         S_L2: begin
            m_in     = mm[32] ? mm[32:1] : mm[31:0];
            frac_in  = {frac_ff[22:0], mm[32]};
            it_in    = it_ff - 5'd1;
            state_in = (it_ff == 5'd1) ? S_LN1 : S_L1;
         end
         S_LN1: state_in = S_LN2;
         S_LN2: begin
            lsum_in  = lsum_ff + 50'(ln_rnd[61:40]) + LN_OFFSET;
            state_in = S_R0;
         end
         S_R0: begin
            d_in     = d_ff - pdev_ext;
            state_in = S_R1;
         end
         S_R1: begin
            if (|dabs[36:31]) begin
               fail_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               mag_in   = dabs[33:0];
               state_in = S_R2;
            end
         end
         S_R2: state_in = S_R3;
         S_R3: begin
            div_quo_in = {2'b0, prod_ff[61:0], 8'b0};
            div_den_in = var_ff;
            div_rem_in = '0;
            div_cnt_in = '0;
            ret_in     = S_R4;
            state_in   = S_DIV;
         end
         S_R4: begin
            if (|div_quo_ff[71:47]) begin
               fail_in = 1'b1;
            end else begin
               lsum_in = lsum_ff + 50'(div_quo_ff[46:0]);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               fail_in   = fail_now;
               sum_in    = fail_now ? $signed(SUM_MAX) : lsum_ff[47:0];
               ptime_in  = t_ff;
               pmag_in   = x_ff;
               pvar_in   = v_ff;
               start_in  = last_ff;
               rsp_data_in.neg2_log_likelihood = fail_now ? $signed(SUM_MAX) : lsum_ff[47:0];
               rsp_data_in.failed     = fail_now;
               rsp_data_in.curve_done = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         sigma_ff     <= SIGMA_RESET;
         tau_ff       <= TAU_RESET;
         mean_ff      <= $signed(MEAN_RESET);
         omega_ff     <= OMEGA_RESET;
         pdev_ff      <= '0;
         pmag_ff      <= '0;
         ptime_ff     <= '0;
         pvar_ff      <= '0;
         sum_ff       <= '0;
         fail_ff      <= 1'b0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sigma_ff     <= sigma_in;
         tau_ff       <= tau_in;
         mean_ff      <= mean_in;
         omega_ff     <= omega_in;
         pdev_ff      <= pdev_in;
         pmag_ff      <= pmag_in;
         ptime_ff     <= ptime_in;
         pvar_ff      <= pvar_in;
         sum_ff       <= sum_in;
         fail_ff      <= fail_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers, no reset
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      v_ff        <= v_in;
      x_ff        <= x_in;
      last_ff     <= last_in;
      sl2_ff      <= sl2_in;
      a_ff        <= a_in;
      a2_ff       <= a2_in;
      k_ff        <= k_in;
      f_ff        <= f_in;
      tmp_ff      <= tmp_in;
      quo_ff      <= quo_in;
      m_ff        <= m_in;
      hk_ff       <= hk_in;
      ncnt_ff     <= ncnt_in;
      it_ff       <= it_in;
      d_ff        <= d_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      ph_ff       <= ph_in;
      t40_ff      <= t40_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      nrm_ff      <= nrm_in;
      var_ff      <= var_in;
      e_ff        <= e_in;
      frac_ff     <= frac_in;
      lsum_ff     <= lsum_in;
      prod_ff     <= prod_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // divider is never started on a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_in == S_DIV && state_ff != S_DIV) |-> (div_den_in != '0))
      else $error("divider started with zero divisor");

   // a failed curve always reports the saturated sum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.failed) |-> (rsp_data.neg2_log_likelihood == $signed(SUM_MAX)))
      else $error("failed result without saturated sum");

   // series term index stays within 1..12
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_H1) |-> (hk_ff >= 4'd1 && hk_ff <= 4'd12))
      else $error("series index out of range");

   // decay never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A2) |-> (a_ff <= ONE_Q32))
      else $error("decay above one");

endmodule
